FILE: hdl/ntc_pkg.sv
// ----------------------------------------------------------------------------
// ntc_pkg: shared types and constants for the number to text cell core
// Holds the transaction record that moves down the digit chain, the decimal
// step table and the character table used for the cell writes.
// ----------------------------------------------------------------------------
package ntc_pkg;

	// screen geometry and chain length
	localparam int SCREEN_COLUMNS = 80;
	localparam int NUM_CELLS      = 10;

	// field widths
	localparam int NUMBER_W = 32;
	localparam int ROW_W    = 5;
	localparam int COL_W    = 7;
	localparam int ADDR_W   = 11;
	localparam int WORD_W   = 16;
	localparam int REM_W    = 40;
	localparam int DEC_W    = 34;
	localparam int DIGS_W   = 4 * NUM_CELLS;
	localparam int START_W  = 14;

	// ascii codes of the hex prefix
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_X    = 8'h78;

	// multiples of one billion, the weight of the top decimal digit
	localparam logic [DEC_W-1:0] DEC_STEP [10] = '{
		34'd0,
		34'd1000000000,
		34'd2000000000,
		34'd3000000000,
		34'd4000000000,
		34'd5000000000,
		34'd6000000000,
		34'd7000000000,
		34'd8000000000,
		34'd9000000000
	};

	// digit to ascii, uppercase hex letters
	localparam logic [7:0] DIGIT_CHARS [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
	};

	// one transaction as it moves from cell to cell
	typedef struct packed {
		logic              valid;
		logic              hex;
		logic [REM_W-1:0]  rem;   // remaining value, top digit aligned
		logic [ADDR_W-1:0] addr;  // first cell address
		logic [7:0]        attr;  // attribute byte
		logic [DIGS_W-1:0] digs;  // significant digits so far, newest lowest
		logic [3:0]        ndig;  // count of significant digits
	} cell_t;

	// emitter status seen by the top level
	typedef struct packed {
		logic active;
		logic finishing;
	} emit_stat_t;

endpackage

FILE: hdl/ntc_cell.sv
// ----------------------------------------------------------------------------
// ntc_cell: one digit cell of the conversion chain
// Peels off the top digit of the remaining value (decimal or hex), drops
// leading zeros and hands the transaction to the next cell.
// ----------------------------------------------------------------------------
module ntc_cell
	import ntc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cell_t prev,
	output cell_t next
);

	logic [DEC_W-1:0] dec_x;
	logic [3:0]       dec_d;
	logic [DEC_W-1:0] dec_r;
	logic [DEC_W-1:0] dec_r30;
	logic [DEC_W-1:0] dec_nxt;
	logic [3:0]       d;
	logic [REM_W-1:0] rem_nxt;
	logic             started;

	// decimal digit: largest multiple of one billion not above the value
	always_comb begin
		dec_x = prev.rem[DEC_W-1:0];
		dec_d = 4'd0;
		for (int m = 1; m < 10; m++) begin
			if (dec_x >= DEC_STEP[m]) begin
				dec_d = 4'(m);
			end
		end
		dec_r   = dec_x - DEC_STEP[dec_d];
		dec_r30 = {4'b0, dec_r[29:0]};
		dec_nxt = (dec_r30 << 3) + (dec_r30 << 1);
	end

	// pick the digit and the shifted remainder for this radix
	always_comb begin
		if (prev.hex) begin
			d       = prev.rem[REM_W-1 -: 4];
			rem_nxt = {prev.rem[REM_W-5:0], 4'b0};
		end else begin
			d       = dec_d;
			rem_nxt = {{(REM_W-DEC_W){1'b0}}, dec_nxt};
		end
		started = (prev.ndig != 4'd0) || (d != 4'd0);
	end

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next <= '0;
		end else begin
			next.valid <= prev.valid;
			next.hex   <= prev.hex;
			next.rem   <= rem_nxt;
			next.addr  <= prev.addr;
			next.attr  <= prev.attr;
			if (started) begin
				next.digs <= {prev.digs[DIGS_W-5:0], d};
				next.ndig <= prev.ndig + 4'd1;
			end else begin
				next.digs <= prev.digs;
				next.ndig <= prev.ndig;
			end
		end
	end

endmodule

FILE: hdl/ntc_emit.sv
// ----------------------------------------------------------------------------
// ntc_emit: cell write emitter
// Takes a finished transaction from the end of the chain and sends its cell
// writes one per cycle: the hex prefix first, then the digits.
// ----------------------------------------------------------------------------
module ntc_emit
	import ntc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cell_t             item,
	output emit_stat_t        stat,
	output logic              strobe,
	output logic [ADDR_W-1:0] cell_address,
	output logic [WORD_W-1:0] cell_word,
	output logic              last
);

	logic [1:0]        pre_q;
	logic [3:0]        left_q;
	logic [DIGS_W-1:0] vec_q;
	logic [ADDR_W-1:0] addr_q;
	logic [7:0]        attr_q;
	logic              strobe_q;
	logic              last_q;
	logic [ADDR_W-1:0] cell_address_q;
	logic [WORD_W-1:0] cell_word_q;

	logic              active;
	logic              fin;
	logic [7:0]        ch;
	logic [3:0]        shamt;
	logic [DIGS_W-1:0] vec_load;
	logic [3:0]        cnt_load;

	// current character and burst status
	always_comb begin
		active = (pre_q != 2'd0) || (left_q != 4'd0);
		fin    = (pre_q == 2'd0) && (left_q == 4'd1);
		if (pre_q == 2'd2) begin
			ch = CHAR_ZERO;
		end else if (pre_q == 2'd1) begin
			ch = CHAR_X;
		end else begin
			ch = DIGIT_CHARS[vec_q[DIGS_W-1 -: 4]];
		end
	end

	// left-align the digits of an arriving transaction, zero shows one digit
	always_comb begin
		shamt    = 4'(NUM_CELLS) - item.ndig;
		vec_load = item.digs << {shamt, 2'b00};
		cnt_load = (item.ndig == 4'd0) ? 4'd1 : item.ndig;
	end

	// burst counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_q    <= 2'd0;
			left_q   <= 4'd0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active;
			if (item.valid) begin
				pre_q  <= item.hex ? 2'd2 : 2'd0;
				left_q <= cnt_load;
			end else if (pre_q != 2'd0) begin
				pre_q <= pre_q - 2'd1;
			end else if (left_q != 4'd0) begin
				left_q <= left_q - 4'd1;
			end
		end
	end

	// burst payload and output registers
	always_ff @(posedge clk) begin
		if (active) begin
			cell_address_q <= addr_q;
			cell_word_q    <= {attr_q, ch};
			last_q         <= fin;
		end
		if (item.valid) begin
			vec_q  <= vec_load;
			addr_q <= item.addr;
			attr_q <= item.attr;
		end else if (active) begin
			addr_q <= addr_q + 11'd1;
			if (pre_q == 2'd0) begin
				vec_q <= {vec_q[DIGS_W-5:0], 4'b0};
			end
		end
	end

	assign stat.active    = active;
	assign stat.finishing = fin;
	assign strobe         = strobe_q;
	assign cell_address   = cell_address_q;
	assign cell_word      = cell_word_q;
	assign last           = strobe_q & last_q;

endmodule

FILE: hdl/number_to_text_cells_core.sv
// ----------------------------------------------------------------------------
// number_to_text_cells_core: 32-bit number to text-mode cell writes
// Renders a number in decimal or 0x-prefixed hex as a burst of cell writes.
// ----------------------------------------------------------------------------
// A number is taken when start is high and busy is low; busy then stays high
// until the single result port has had time for the longest burst of ten
// cells, so a new number can be taken while the last is still in the chain.
// The digits are worked out in a chain of ten cells, one digit per cell, and
// the cell writes of a number are then shown one after another, in
// consecutive cycles. Each write is shown for exactly one cycle with strobe
// high and cannot be held off, so the receiver must take every strobe; last
// marks the final write of a number.
module number_to_text_cells_core
	import ntc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [NUMBER_W-1:0] number,
	input  logic                hex_mode,
	input  logic [ROW_W-1:0]    row,
	input  logic [COL_W-1:0]    col,
	input  logic [3:0]          fore,
	input  logic [3:0]          back,
	output logic                strobe,
	output logic [ADDR_W-1:0]   cell_address,
	output logic [WORD_W-1:0]   cell_word,
	output logic                last
);

	logic [3:0]         gap_q;
	logic               accept;
	logic [START_W-1:0] start_addr;
	cell_t              chain [NUM_CELLS+1];
	emit_stat_t         stat;

	// input acceptance and spacing of transactions
	assign accept = start & ~busy;
	assign busy   = (gap_q != 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= 4'd0;
		end else if (accept) begin
			gap_q <= 4'(NUM_CELLS - 1);
		end else if (gap_q != 4'd0) begin
			gap_q <= gap_q - 4'd1;
		end
	end

	// start address and record entering the chain
	assign start_addr = START_W'(row) * START_W'(SCREEN_COLUMNS) + START_W'(col);

	always_comb begin
		chain[0].valid = accept;
		chain[0].hex   = hex_mode;
		chain[0].rem   = {{(REM_W-NUMBER_W){1'b0}}, number};
		chain[0].addr  = start_addr[ADDR_W-1:0];
		chain[0].attr  = {back, fore};
		chain[0].digs  = '0;
		chain[0].ndig  = 4'd0;
	end

	// digit chain
	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		ntc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.prev   (chain[i]),
			.next   (chain[i+1])
		);
	end

	// cell write emitter
	ntc_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (chain[NUM_CELLS]),
		.stat         (stat),
		.strobe       (strobe),
		.cell_address (cell_address),
		.cell_word    (cell_word),
		.last         (last)
	);

	// an accepted transaction holds off the next one
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("start taken without busy in the following cycle");

	// last only marks a shown cell write
	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> strobe)
		else $error("last without strobe");

	// a new transaction reaches the emitter only when the previous burst ends
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		chain[NUM_CELLS].valid |-> (!stat.active || stat.finishing))
		else $error("emitter loaded while a burst is still in progress");

endmodule

FILE: verif/number_to_text_cells_checker.sv
// ----------------------------------------------------------------------------
// number_to_text_cells_checker: scoreboard for the number to text cell core
// Watches the start/busy handshake, renders every accepted number into the
// cell writes it should cause, and compares each strobed write in order.
// ----------------------------------------------------------------------------
module number_to_text_cells_checker
	import ntc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic [NUMBER_W-1:0] number,
	input  logic                hex_mode,
	input  logic [ROW_W-1:0]    row,
	input  logic [COL_W-1:0]    col,
	input  logic [3:0]          fore,
	input  logic [3:0]          back,
	input  logic                strobe,
	input  logic [ADDR_W-1:0]   cell_address,
	input  logic [WORD_W-1:0]   cell_word,
	input  logic                last,
	output int                  mismatches,
	output int                  cells_due,
	output int                  cells_checked
);

	localparam int REPORT_LIMIT = 10;

	// one expected cell write
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] word;
		logic              last;
	} cell_write_t;

	cell_write_t expected_writes[$];

	// render one number into its burst of cell writes
	function automatic void render_number(
		input logic [NUMBER_W-1:0] value,
		input logic                hex,
		input logic [ROW_W-1:0]    r,
		input logic [COL_W-1:0]    c,
		input logic [3:0]          f,
		input logic [3:0]          b
	);
		logic [7:0]          text[$];
		logic [NUMBER_W-1:0] rest;
		logic [NUMBER_W-1:0] weight;
		logic [NUMBER_W-1:0] digit;
		logic [NUMBER_W-1:0] radix;
		int unsigned         first_addr;
		bit                  seen_nonzero;
		cell_write_t         wr;

		rest         = value;
		radix        = hex ? 32'd16 : 32'd10;
		weight       = hex ? 32'h1000_0000 : 32'd1_000_000_000;
		seen_nonzero = 1'b0;
		first_addr   = r * SCREEN_COLUMNS + c;

		// prefix and the lone zero
		if (hex) begin
			text.push_back(CHAR_ZERO);
			text.push_back(CHAR_X);
		end
		if (value == '0) begin
			text.push_back(CHAR_ZERO);
		end

		// significant digits, most significant first
		while (weight != '0) begin
			digit = rest / weight;
			if (digit != '0)
				seen_nonzero = 1'b1;
			if (seen_nonzero && text.size() < NUM_CELLS) begin
				if (digit < 10)
					text.push_back(CHAR_ZERO + digit[7:0]);
				else
					text.push_back(8'h41 + digit[7:0] - 8'd10);
			end
			rest   = rest % weight;
			weight = weight / radix;
		end

		// consecutive addresses, low bits only, flag on the final cell
		foreach (text[k]) begin
			wr.addr = ADDR_W'(first_addr + k);
			wr.word = {b, f, text[k]};
			wr.last = (k == text.size() - 1);
			expected_writes.push_back(wr);
		end
	endfunction

	// compare strobed writes, then queue the transaction taken at this edge
	always @(posedge clk) begin
		cell_write_t want;
		if (arst_n) begin
			if (strobe) begin
				if (expected_writes.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: unexpected cell write addr %0d word %h last %b",
							$time, cell_address, cell_word, last);
				end else begin
					want = expected_writes.pop_front();
					cells_checked++;
					if (cell_address !== want.addr || cell_word !== want.word ||
						last !== want.last) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display(
							"%0t: exp addr %0d word %h last %b, got addr %0d word %h last %b",
								$time, want.addr, want.word, want.last,
								cell_address, cell_word, last);
					end
				end
			end
			if (start && !busy)
				render_number(number, hex_mode, row, col, fore, back);
			cells_due = expected_writes.size();
		end
	end

endmodule

FILE: verif/number_to_text_cells_core_tb.sv
// ----------------------------------------------------------------------------
// number_to_text_cells_core_tb: testbench for the number to text cell core
// Sends directed corner numbers and then random ones in both radixes, at
// random screen positions and colours, with random gaps on the command side;
// a checker beside the core predicts and compares every cell write.
// ----------------------------------------------------------------------------
module number_to_text_cells_core_tb;
	import ntc_pkg::*;

	localparam int RANDOM_NUMBERS = 230;
	localparam int SETTLE_CYCLES  = 30;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [NUMBER_W-1:0] number;
	logic                hex_mode;
	logic [ROW_W-1:0]    row;
	logic [COL_W-1:0]    col;
	logic [3:0]          fore;
	logic [3:0]          back;
	logic                strobe;
	logic [ADDR_W-1:0]   cell_address;
	logic [WORD_W-1:0]   cell_word;
	logic                last;

	int mismatches;
	int cells_due;
	int cells_checked;
	int numbers_sent;
	int hex_sent;

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run time limit
	initial begin
		#200000;
		$display("TEST FAILED");
		$finish;
	end

	number_to_text_cells_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.number       (number),
		.hex_mode     (hex_mode),
		.row          (row),
		.col          (col),
		.fore         (fore),
		.back         (back),
		.strobe       (strobe),
		.cell_address (cell_address),
		.cell_word    (cell_word),
		.last         (last)
	);

	number_to_text_cells_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.number        (number),
		.hex_mode      (hex_mode),
		.row           (row),
		.col           (col),
		.fore          (fore),
		.back          (back),
		.strobe        (strobe),
		.cell_address  (cell_address),
		.cell_word     (cell_word),
		.last          (last),
		.mismatches    (mismatches),
		.cells_due     (cells_due),
		.cells_checked (cells_checked)
	);

	// one transaction: hold start until busy is low, return after the taking edge
	task automatic send_number(
		input logic [NUMBER_W-1:0] n,
		input logic                h,
		input logic [ROW_W-1:0]    r,
		input logic [COL_W-1:0]    c,
		input logic [3:0]          f,
		input logic [3:0]          b
	);
		@(negedge clk);
		number   <= n;
		hex_mode <= h;
		row      <= r;
		col      <= c;
		fore     <= f;
		back     <= b;
		start    <= 1'b1;
		while (busy)
			@(negedge clk);
		@(posedge clk);
		numbers_sent++;
		if (h)
			hex_sent++;
	endtask

	// stimulus
	initial begin
		logic [NUMBER_W-1:0] value;
		logic [NUMBER_W-1:0] tenpow;
		logic [ROW_W-1:0]    r;
		logic [COL_W-1:0]    c;
		bit                  steady;

		arst_n   = 1'b0;
		start    = 1'b0;
		number   = '0;
		hex_mode = 1'b0;
		row      = '0;
		col      = '0;
		fore     = '0;
		back     = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed corners, back to back
		send_number(32'd0,          1'b0, 5'd0,  7'd0,   4'd0,  4'd0);
		send_number(32'd0,          1'b1, 5'd24, 7'd79,  4'd15, 4'd15);
		send_number(32'hFFFF_FFFF,  1'b0, 5'd31, 7'd127, 4'd5,  4'd10);
		send_number(32'hFFFF_FFFF,  1'b1, 5'd25, 7'd100, 4'd10, 4'd5);
		send_number(32'd1,          1'b0, 5'd1,  7'd1,   4'd1,  4'd0);
		send_number(32'd9,          1'b0, 5'd2,  7'd78,  4'd7,  4'd1);
		send_number(32'd10,         1'b0, 5'd3,  7'd40,  4'd2,  4'd8);
		send_number(32'd999999999,  1'b0, 5'd4,  7'd0,   4'd14, 4'd3);
		send_number(32'd1000000000, 1'b0, 5'd5,  7'd70,  4'd12, 4'd6);
		send_number(32'd4000000000, 1'b0, 5'd6,  7'd5,   4'd9,  4'd4);
		send_number(32'h1000_0000,  1'b1, 5'd7,  7'd20,  4'd3,  4'd12);
		send_number(32'h0FFF_FFFF,  1'b1, 5'd8,  7'd72,  4'd6,  4'd9);
		send_number(32'h89AB_CDEF,  1'b1, 5'd9,  7'd33,  4'd11, 4'd2);
		send_number(32'h0000_000F,  1'b1, 5'd10, 7'd11,  4'd4,  4'd14);
		send_number(32'h7FFF_FFFF,  1'b0, 5'd11, 7'd64,  4'd8,  4'd7);
		// burst that crosses the top of the address range
		send_number(32'd12345,      1'b0, 5'd25, 7'd47,  4'd13, 4'd11);

		// let the directed transactions drain completely
		@(negedge clk);
		start <= 1'b0;
		while (cells_due != 0)
			@(negedge clk);

		// random numbers, mixed magnitudes and positions
		for (int i = 0; i < RANDOM_NUMBERS; i++) begin
			steady = (i >= 120 && i < 170);
			case ($urandom_range(0, 5))
				0: value = $urandom_range(0, 15);
				1: begin
					tenpow = 32'd1;
					repeat ($urandom_range(0, 9))
						tenpow = tenpow * 10;
					value = tenpow + $urandom_range(0, 2) - 1;
				end
				2: value = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
				3: value = $urandom() >> $urandom_range(0, 31);
				default: value = $urandom();
			endcase
			r = ROW_W'(($urandom_range(0, 9) == 0) ?
				$urandom_range(25, 31) : $urandom_range(0, 24));
			c = COL_W'(($urandom_range(0, 9) == 0) ?
				$urandom_range(80, 127) : $urandom_range(0, 79));
			send_number(value, 1'($urandom_range(0, 1)), r, c,
				4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));

			// sender gap with noise on the fields
			if (!steady && $urandom_range(0, 99) < 31) begin
				repeat ($urandom_range(1, 14)) begin
					@(negedge clk);
					start    <= 1'b0;
					number   <= $urandom();
					hex_mode <= 1'($urandom_range(0, 1));
					row      <= ROW_W'($urandom());
					col      <= COL_W'($urandom());
					fore     <= 4'($urandom());
					back     <= 4'($urandom());
				end
			end

			// wait out every pending write once, a third of the way into the run
			if (i == RANDOM_NUMBERS / 3) begin
				@(negedge clk);
				start <= 1'b0;
				while (cells_due != 0)
					@(negedge clk);
			end
		end

		// drain and settle
		@(negedge clk);
		start <= 1'b0;
		while (cells_due != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("sent %0d numbers (%0d hex, %0d decimal), checked %0d cell writes",
			numbers_sent, hex_sent, numbers_sent - hex_sent, cells_checked);
		$display("mismatches: %0d", mismatches);
		if (mismatches == 0 && cells_due == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
